// File: rtl/assert_macros.svh
// Assertion macros shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// File: rtl/mia_pkg.sv
// Package: types, constants and log helper for the MI accumulator.
`timescale 1ns / 1ps
package mia_pkg;
  localparam int ProbFracBits = 16;
  localparam int ProbWidth = ProbFracBits + 1;
  localparam int LogRounds = 16;
  localparam int ExpWidth = 5;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [ProbWidth-1:0] marginal_first;
    logic [ProbWidth-1:0] marginal_second;
    logic [ProbWidth-1:0] joint_prob;
    logic                 last_cell;
  } mia_in_t;

  typedef struct packed {
    logic signed [31:0] mutual_information;
    logic               saturated;
  } mia_out_t;

  // Classified job for the back end.
  typedef struct packed {
    logic                 active;
    logic                 last_cell;
    logic [ProbWidth-1:0] joint_prob;
    logic [ProbWidth-1:0] m1;
    logic [ProbWidth-1:0] m2;
  } mia_job_t;

  // Index of the top set bit of a nonzero value.
  function automatic logic [ExpWidth-1:0] top_bit(input logic [ProbWidth-1:0] x);
    logic [ExpWidth-1:0] e;
    e = '0;
    for (int i = 0; i < ProbWidth; i++) begin
      if (x[i]) e = ExpWidth'(i);
    end
    return e;
  endfunction
endpackage

// File: rtl/mia_front.sv
// Front end: accepts cells, flags zero cells, queues jobs.
`timescale 1ns / 1ps
module mia_front import mia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mia_in_t  in_data_i,
  output logic     job_valid_o,
  input  logic     job_take_i,
  output mia_job_t job_o
);
  mia_job_t q_mem_q [QueueDepth];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic push, pop;
  mia_job_t job;

  assign in_stall_o = (cnt_q == 2'(QueueDepth));
  assign push = in_valid_i && !in_stall_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop = job_valid_o && job_take_i;
  assign job_o = q_mem_q[rd_q];

  always_comb begin
    job.active = (in_data_i.marginal_first != '0) && (in_data_i.marginal_second != '0)
                 && (in_data_i.joint_prob != '0);
    job.last_cell = in_data_i.last_cell;
    job.joint_prob = in_data_i.joint_prob;
    job.m1 = in_data_i.marginal_first;
    job.m2 = in_data_i.marginal_second;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[wr_q] <= job;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/mia_back.sv
// Back end: sequential log2, ln scaling, saturating accumulate.
`timescale 1ns / 1ps
module mia_back import mia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_valid_i,
  output logic     job_take_o,
  input  mia_job_t job_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mia_out_t out_data_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SQR, S_NEXT, S_LN, S_TERM, S_ACC
  } state_e;

  state_e state_q;
  mia_job_t job_q;
  logic [1:0] which_q;
  logic [4:0] round_q;
  logic [31:0] m_q;
  logic [15:0] frac_q;
  logic signed [23:0] d_q;
  logic signed [23:0] l_q;
  logic signed [32:0] term_q;
  logic signed [31:0] sum_q;
  logic clip_q;
  logic out_valid_q;
  mia_out_t out_q;

  logic [ProbWidth-1:0] opnd;
  logic [ExpWidth-1:0] e;
  logic [63:0] sq;
  logic [33:0] msq;
  logic signed [23:0] lg;
  logic signed [53:0] dprod;
  logic [53:0] dmag;
  logic signed [23:0] lnr;
  logic signed [41:0] tprod;
  logic [41:0] tmag;
  logic signed [32:0] trm, s33;
  logic signed [31:0] sat;
  logic clip;

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign job_take_o = (state_q == S_IDLE) && job_valid_i &&
                      !(job_i.last_cell && !job_i.active && out_valid_q);

  always_comb begin
    unique case (which_q)
      2'd0: opnd = job_q.joint_prob;
      2'd1: opnd = job_q.m1;
      default: opnd = job_q.m2;
    endcase
    e = top_bit(opnd);
    sq = 64'(m_q) * 64'(m_q);
    msq = sq[63:30];
    lg = (24'(e) - 24'(ProbFracBits)) * 24'sd65536 + 24'(frac_q);
    dprod = 54'(d_q) * $signed({24'd0, Ln2Q30});
    dmag = dprod[53] ? -dprod : dprod;
    dmag = (dmag + (54'd1 << 29)) >> 30;
    lnr = dprod[53] ? -24'(dmag) : 24'(dmag);
    tprod = 42'(l_q) * $signed({25'd0, job_q.joint_prob});
    tmag = tprod[41] ? -tprod : tprod;
    tmag = (tmag + (42'd1 << (ProbFracBits - 1))) >> ProbFracBits;
    trm = tprod[41] ? -33'(tmag) : 33'(tmag);
    // registered term keeps the multiply apart from the saturating add
    s33 = 33'(sum_q) + term_q;
    clip = (s33[32] != s33[31]);
    sat = clip ? (s33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : s33[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      sum_q <= '0;
      clip_q <= 1'b0;
      which_q <= '0;
      round_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (job_take_o) begin
          job_q <= job_i;
          which_q <= 2'd0;
          d_q <= '0;
          if (job_i.active) state_q <= S_LOAD;
          else if (job_i.last_cell) begin
            out_q <= '{mutual_information: sum_q, saturated: clip_q};
            out_valid_q <= 1'b1;
            sum_q <= '0;
            clip_q <= 1'b0;
          end
        end
        S_LOAD: begin
          m_q <= 32'(opnd) << (30 - int'(e));
          frac_q <= '0;
          round_q <= '0;
          state_q <= S_SQR;
        end
        S_SQR: begin
          if (msq[33:31] != 3'd0) begin
            m_q <= msq[32:1];
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            m_q <= msq[31:0];
            frac_q <= {frac_q[14:0], 1'b0};
          end
          if (round_q == 5'(LogRounds - 1)) state_q <= S_NEXT;
          round_q <= round_q + 5'd1;
        end
        S_NEXT: begin
          d_q <= (which_q == 2'd0) ? d_q + lg : d_q - lg;
          if (which_q == 2'd2) state_q <= S_LN;
          else begin
            which_q <= which_q + 2'd1;
            state_q <= S_LOAD;
          end
        end
        S_LN: begin
          l_q <= lnr;
          state_q <= S_TERM;
        end
        S_TERM: begin
          term_q <= trm;
          state_q <= S_ACC;
        end
        S_ACC: if (!(job_q.last_cell && out_valid_q)) begin
          state_q <= S_IDLE;
          if (job_q.last_cell) begin
            out_q <= '{mutual_information: sat, saturated: clip_q | clip};
            out_valid_q <= 1'b1;
            sum_q <= '0;
            clip_q <= 1'b0;
          end else begin
            sum_q <= sat;
            clip_q <= clip_q | clip;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/mutual_information_accumulator.sv
// Top level of the mutual information accumulator.
// Each accepted word is one joint-histogram cell (Q1.16 joint and two
// marginals). Cells with all three nonzero add joint*ln(joint/(m1*m2)) to a
// saturating Q15.16 sum in nats; the last cell emits the sum and clip flag.
// The front end accepts a cell per cycle, unless the two-entry queue is
// full. The back end takes a cell from the queue only when idle, computes
// three log2 values one after another (load, 16 squaring rounds, combine),
// then steps through ln scaling, term and accumulate; a zero cell is done
// as soon as it is taken. A last cell that finds the previous result word
// still waiting is held until that word is taken. The shared squaring
// multiplier keeps the back end to one cell at a time.
`timescale 1ns / 1ps
module mutual_information_accumulator import mia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  mia_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mia_out_t out_data_o
);
  logic job_valid, job_take;
  mia_job_t job;

  mia_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  mia_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_take_o(job_take),
    .job_i(job), .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

// File: rtl/mia_checker.sv
// Port-level checker for the MI accumulator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mia_checker import mia_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input mia_out_t out_data_o
);
  logic [3:0] ctl;
  assign ctl = {in_valid_i, in_stall_o, out_valid_o, out_stall_i};

  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `CHK_NEXT(a_one_word, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o)
  `CHK_IMPL(a_ctl_known, clk_i, rst_ni, 1'b1, !$isunknown(ctl))
  `CHK_IMPL(a_data_known, clk_i, rst_ni, out_valid_o, !$isunknown(out_data_o))
endmodule

bind mutual_information_accumulator mia_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
